FILE: hw/rtl/tlbipt_pkg.sv
// ----------------------------------------------------------------------------
// tlbipt_pkg
// shared types and constants of the tlb / inverted page table mmu
// ----------------------------------------------------------------------------
`default_nettype none

package tlbipt_pkg;

    // flag bits of tlb and frame entries
    localparam int FL_DIRTY = 0;
    localparam int FL_USE   = 1;
    localparam int FL_RO    = 2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ALIGN = 2'd1;
    localparam logic [1:0] ST_RO    = 2'd2;

    // access size codes
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam int IN_BITS  = 72;
    localparam int OUT_BITS = 56;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_CHECK,
        CMD_SCAN_LOOK,
        CMD_SCAN_EVICT,
        CMD_EVICT,
        CMD_INSTALL,
        CMD_CHOOSE,
        CMD_SCAN_VIC,
        CMD_COPY,
        CMD_REFILL,
        CMD_UPD_F,
        CMD_LOAD_OUT
    } t_cmd;

    typedef struct packed {
        logic align_err;
        logic tlb_hit;
        logic scan_last;
        logic frame_hit;
        logic free_found;
        logic ro_write;
        logic fault;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/tlbipt_datapath.sv
// ----------------------------------------------------------------------------
// tlbipt_datapath
// tlb, frame table, scan counter and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module tlbipt_datapath
    import tlbipt_pkg::*;
#(
    parameter int TLB_ENTRIES = 4,
    parameter int FRAMES      = 32,
    parameter int PAGE_BYTES  = 128
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    input  wire logic [IN_BITS-1:0]  i_in_data,
    input  wire logic                i_cfg_we,
    input  wire logic [7:0]          i_cfg_data,
    output t_dp_stat                 o_stat,
    output logic [OUT_BITS-1:0]      o_out_data
);

    localparam int OB = $clog2(PAGE_BYTES);
    localparam int VW = 32 - OB;
    localparam int FW = $clog2(FRAMES);
    localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    logic [7:0]    r_asid;
    logic [31:0]   r_va;
    logic [1:0]    r_size;
    logic          r_wr;
    logic [31:0]   r_now;

    // tlb
    logic          r_tv  [TLB_ENTRIES];
    logic [VW-1:0] r_tp  [TLB_ENTRIES];
    logic [FW-1:0] r_tf  [TLB_ENTRIES];
    logic [2:0]    r_tfl [TLB_ENTRIES];
    logic [31:0]   r_tlu [TLB_ENTRIES];

    // frame table
    logic          r_fv  [FRAMES];
    logic [VW-1:0] r_fp  [FRAMES];
    logic [7:0]    r_fo  [FRAMES];
    logic [2:0]    r_ffl [FRAMES];
    logic [31:0]   r_flu [FRAMES];

    logic [FW-1:0] r_idx, r_f, r_free, r_victim, r_vf;
    logic          r_fhit, r_free_v, r_vic_v, r_vf_v, r_fault;
    logic [31:0]   r_minlu;
    logic [TW-1:0] r_slot;
    logic [VW-1:0] r_tpage;

    // pending result
    logic [1:0]    r_status;
    logic [11:0]   r_pa;
    logic          r_missed, r_faulted, r_wb;
    logic [24:0]   r_epage;
    logic [7:0]    r_eowner;
    logic [OUT_BITS-1:0] r_out;

    logic [VW-1:0] vpn;
    logic [OB-1:0] off;
    logic          align_err;
    logic          hit;
    logic [TW-1:0] hit_idx;
    logic [FW-1:0] rd;
    logic          rd_v;
    logic [VW-1:0] rd_p;
    logic [7:0]    rd_o;
    logic [2:0]    rd_fl;
    logic [31:0]   rd_lu;
    logic          ref_hit;
    logic [TW-1:0] ref_idx;
    logic [31:0]   eff_lu;
    logic          inv_hit;
    logic [TW-1:0] inv_idx;
    logic          any_inv;
    logic [TW-1:0] slot;
    logic [31:0]   oldest;

    assign vpn = r_va[31:OB];
    assign off = r_va[OB-1:0];
    assign align_err = ((r_size == SZ_WORD) && (r_va[1:0] != 2'd0)) ||
                       ((r_size == SZ_HALF) && r_va[0]);

    // one read port of the frame table
    always_comb begin
        case (i_cmd)
            CMD_EVICT:              rd = r_victim;
            CMD_REFILL, CMD_UPD_F:  rd = r_f;
            default:                rd = r_idx;
        endcase
        rd_v  = r_fv[rd];
        rd_p  = r_fp[rd];
        rd_o  = r_fo[rd];
        rd_fl = r_ffl[rd];
        rd_lu = r_flu[rd];
    end

    // tlb hit, first match
    always_comb begin
        hit = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!hit && r_tv[i] && (r_tp[i] == vpn)) begin
                hit = 1'b1;
                hit_idx = TW'(i);
            end
        end
    end

    // refresh source for the scanned frame: last tlb entry with its page
    always_comb begin
        ref_hit = 1'b0;
        ref_idx = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (r_tp[i] == rd_p) begin
                ref_hit = 1'b1;
                ref_idx = TW'(i);
            end
        end
        ref_hit = ref_hit && (rd_o == r_asid);
        eff_lu = ref_hit ? r_tlu[ref_idx] : rd_lu;
    end

    // first valid tlb entry holding the evicted page
    always_comb begin
        inv_hit = 1'b0;
        inv_idx = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!inv_hit && r_tv[i] && (r_tp[i] == rd_p)) begin
                inv_hit = 1'b1;
                inv_idx = TW'(i);
            end
        end
    end

    // tlb victim: last invalid entry, else lru among entry 0 and the entries with use set
    always_comb begin
        any_inv = 1'b0;
        slot = '0;
        oldest = r_tlu[0];
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!r_tv[i]) begin
                any_inv = 1'b1;
                slot = TW'(i);
            end
        end
        if (!any_inv) begin
            for (int i = 1; i < TLB_ENTRIES; i++) begin
                if (r_tfl[i][FL_USE] && (r_tlu[i] < oldest)) begin
                    oldest = r_tlu[i];
                    slot = TW'(i);
                end
            end
        end
    end

    always_comb begin
        o_stat.align_err  = align_err;
        o_stat.tlb_hit    = hit;
        o_stat.scan_last  = (r_idx == FW'(FRAMES - 1));
        o_stat.frame_hit  = r_fhit;
        o_stat.free_found = r_free_v;
        o_stat.ro_write   = rd_fl[FL_RO] && r_wr;
        o_stat.fault      = r_fault;
    end

    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asid <= '0;
            r_idx  <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_tv[i]  <= 1'b0;
                r_tp[i]  <= '0;
                r_tf[i]  <= '0;
                r_tfl[i] <= '0;
                r_tlu[i] <= '0;
            end
            for (int i = 0; i < FRAMES; i++) begin
                r_fv[i]  <= 1'b0;
                r_fp[i]  <= '0;
                r_fo[i]  <= '0;
                r_ffl[i] <= '0;
                r_flu[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_asid <= i_cfg_data;
            end
            unique case (i_cmd)
                CMD_ACCEPT: begin
                    r_va      <= i_in_data[31:0];
                    r_size    <= i_in_data[33:32];
                    r_wr      <= i_in_data[34];
                    r_now     <= i_in_data[66:35];
                    r_fhit    <= 1'b0;
                    r_free_v  <= 1'b0;
                    r_vic_v   <= 1'b0;
                    r_fault   <= 1'b0;
                    r_status  <= ST_OK;
                    r_pa      <= '0;
                    r_missed  <= 1'b0;
                    r_faulted <= 1'b0;
                    r_wb      <= 1'b0;
                    r_epage   <= '0;
                    r_eowner  <= '0;
                end
                CMD_CHECK: begin
                    if (align_err) begin
                        r_status <= ST_ALIGN;
                    end else if (hit) begin
                        r_tfl[hit_idx][FL_USE] <= 1'b1;
                        r_tlu[hit_idx] <= r_now;
                        if (r_tfl[hit_idx][FL_RO] && r_wr) begin
                            r_status <= ST_RO;
                        end else begin
                            if (r_wr) r_tfl[hit_idx][FL_DIRTY] <= 1'b1;
                            r_pa <= 12'({r_tf[hit_idx], off});
                        end
                    end
                end
                CMD_SCAN_LOOK: begin
                    if (rd_v && (rd_o == r_asid) && (rd_p == vpn)) begin
                        r_f    <= r_idx;
                        r_fhit <= 1'b1;
                    end
                    if (!rd_v && !r_free_v) begin
                        r_free   <= r_idx;
                        r_free_v <= 1'b1;
                    end
                    r_idx <= o_stat.scan_last ? '0 : r_idx + 1'b1;
                end
                CMD_SCAN_EVICT: begin
                    if (rd_v) begin
                        if (ref_hit) begin
                            r_ffl[rd] <= r_tfl[ref_idx];
                            r_flu[rd] <= r_tlu[ref_idx];
                        end
                        if (!r_vic_v || (eff_lu < r_minlu)) begin
                            r_victim <= r_idx;
                            r_minlu  <= eff_lu;
                            r_vic_v  <= 1'b1;
                        end
                    end
                    r_idx <= o_stat.scan_last ? '0 : r_idx + 1'b1;
                end
                CMD_EVICT: begin
                    if (rd_fl[FL_DIRTY]) begin
                        r_wb     <= 1'b1;
                        r_epage  <= 25'(rd_p);
                        r_eowner <= rd_o;
                    end
                    r_ffl[rd][FL_DIRTY] <= 1'b0;
                    r_fv[rd] <= 1'b0;
                    if ((rd_o == r_asid) && inv_hit) begin
                        r_tv[inv_idx] <= 1'b0;
                    end
                    r_free <= r_victim;
                end
                CMD_INSTALL: begin
                    r_fv[r_free]  <= 1'b1;
                    r_fp[r_free]  <= vpn;
                    r_ffl[r_free] <= 3'b1 << FL_USE;
                    r_flu[r_free] <= r_now;
                    r_fo[r_free]  <= r_asid;
                    r_f     <= r_free;
                    r_fault <= 1'b1;
                end
                CMD_CHOOSE: begin
                    r_tfl[slot][FL_USE] <= 1'b1;
                    r_tlu[slot] <= r_now;
                    r_slot  <= slot;
                    r_tpage <= r_tp[slot];
                    r_vf_v  <= 1'b0;
                end
                CMD_SCAN_VIC: begin
                    if (rd_v && (rd_o == r_asid) && (rd_p == r_tpage)) begin
                        r_vf   <= r_idx;
                        r_vf_v <= 1'b1;
                    end
                    r_idx <= o_stat.scan_last ? '0 : r_idx + 1'b1;
                end
                CMD_COPY: begin
                    if (r_vf_v) begin
                        r_ffl[r_vf] <= r_tfl[r_slot];
                        r_flu[r_vf] <= r_tlu[r_slot];
                    end
                end
                CMD_REFILL: begin
                    r_tp[r_slot]  <= rd_p;
                    r_tf[r_slot]  <= r_f;
                    r_tv[r_slot]  <= rd_v;
                    r_tfl[r_slot] <= rd_fl;
                    if (!r_fault) begin
                        r_missed <= 1'b1;
                        r_pa     <= 12'({r_f, off});
                    end
                end
                CMD_UPD_F: begin
                    r_ffl[rd][FL_USE] <= 1'b1;
                    if (r_wr) r_ffl[rd][FL_DIRTY] <= 1'b1;
                    r_flu[rd] <= r_now;
                    if (rd_fl[FL_RO] && r_wr) begin
                        r_status <= ST_RO;
                    end else if (r_fault) begin
                        r_missed  <= 1'b1;
                        r_faulted <= 1'b1;
                        r_pa      <= 12'({r_f, off});
                    end
                end
                CMD_LOAD_OUT: begin
                    r_out <= {6'd0, r_eowner, r_epage, r_wb, r_faulted, r_missed,
                              (r_status == ST_OK) ? r_pa : 12'd0, r_status};
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tlbipt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbipt_ctrl
// sequencer of one access: lookup, table walks, eviction, refill
// ----------------------------------------------------------------------------
`default_nettype none

module tlbipt_ctrl
    import tlbipt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_cmd          o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_LOOK, S_LOOK_END, S_EVSCAN, S_EVICT, S_INSTALL,
        S_CHOOSE, S_VICSCAN, S_COPY, S_REFILL, S_UPD, S_DONE
    } t_state;

    t_state r_state;
    logic   load;

    assign load = (r_state == S_DONE) && (!o_out_valid || i_out_ready);

    always_comb begin
        unique case (r_state)
            S_IDLE:     o_cmd = (i_in_valid && o_in_ready) ? CMD_ACCEPT : CMD_NONE;
            S_CHECK:    o_cmd = CMD_CHECK;
            S_LOOK:     o_cmd = CMD_SCAN_LOOK;
            S_LOOK_END: o_cmd = CMD_NONE;
            S_EVSCAN:   o_cmd = CMD_SCAN_EVICT;
            S_EVICT:    o_cmd = CMD_EVICT;
            S_INSTALL:  o_cmd = CMD_INSTALL;
            S_CHOOSE:   o_cmd = CMD_CHOOSE;
            S_VICSCAN:  o_cmd = CMD_SCAN_VIC;
            S_COPY:     o_cmd = CMD_COPY;
            S_REFILL:   o_cmd = CMD_REFILL;
            S_UPD:      o_cmd = CMD_UPD_F;
            S_DONE:     o_cmd = load ? CMD_LOAD_OUT : CMD_NONE;
            default:    o_cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_in_ready  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        o_in_ready <= 1'b0;
                        r_state <= S_CHECK;
                    end else begin
                        o_in_ready <= 1'b1;
                    end
                end
                S_CHECK: begin
                    r_state <= (i_stat.align_err || i_stat.tlb_hit) ? S_DONE : S_LOOK;
                end
                S_LOOK:     if (i_stat.scan_last) r_state <= S_LOOK_END;
                S_LOOK_END: begin
                    if (i_stat.frame_hit)       r_state <= S_UPD;
                    else if (i_stat.free_found) r_state <= S_INSTALL;
                    else                        r_state <= S_EVSCAN;
                end
                S_EVSCAN:   if (i_stat.scan_last) r_state <= S_EVICT;
                S_EVICT:    r_state <= S_INSTALL;
                S_INSTALL:  r_state <= S_CHOOSE;
                S_CHOOSE:   r_state <= S_VICSCAN;
                S_VICSCAN:  if (i_stat.scan_last) r_state <= S_COPY;
                S_COPY:     r_state <= S_REFILL;
                S_REFILL:   r_state <= i_stat.fault ? S_UPD : S_DONE;
                S_UPD: begin
                    if (i_stat.ro_write || i_stat.fault) r_state <= S_DONE;
                    else                                 r_state <= S_CHOOSE;
                end
                S_DONE: begin
                    if (load) begin
                        o_in_ready  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tlb_inverted_page_table_mmu.sv
// ----------------------------------------------------------------------------
// tlb_inverted_page_table_mmu
// address translation through a small tlb backed by an inverted frame table
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                        payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  access (va, size, write, tick)
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  result (status, pa, flags)
// cfg       in   i_cfg_valid/o_cfg_ready          address space id
//
// one access at a time; a tlb hit or an alignment error goes straight to the result;
// a tlb miss walks the frame table one entry a cycle for the page, again for a frame
// to evict when needed and, unless a read-only write ends it, for the tlb victim
// (the table read port); reset clears tlb, frame table and the address space id
// at once; a finished result waits in the output register; the next beat is taken
// while it waits, and the sequencer stalls only at the end of that access
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_inverted_page_table_mmu
    import tlbipt_pkg::*;
#(
    parameter int TLB_ENTRIES = 4,
    parameter int FRAMES      = 32,
    parameter int PAGE_BYTES  = 128
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // virtual_address, access_size, is_write, now_tick, zero fill
    input  wire logic [IN_BITS-1:0]  i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // status, physical_address, tlb_missed, page_faulted, writeback_needed,
    // evicted_page, evicted_owner, zero fill
    output logic [OUT_BITS-1:0]      o_m_axis_tdata,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [7:0]          i_cfg_data
);

    t_cmd     cmd;
    t_dp_stat stat;

    // the id register takes any write beat
    assign o_cfg_ready = 1'b1;

    tlbipt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tlbipt_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .FRAMES      (FRAMES),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_s_axis_tdata),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_out_data (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
